// ===== design/lru_page_replacement_top_macros.svh =====
// Assertion macros shared by the LRU page replacement modules.
`ifndef LRU_PAGE_REPLACEMENT_TOP_MACROS_SVH
`define LRU_PAGE_REPLACEMENT_TOP_MACROS_SVH

// A property checked at every rising clock edge outside reset.
`define LRUPR_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define LRUPR_ASSERT_NEXT(name, trig, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/lrupr_pkg.sv =====
// Types, constants and helper functions of the LRU page replacement block.
package lrupr_pkg;

  localparam int FRAMES    = 16;
  localparam int PAGE_BITS = 16;
  localparam int FRAME_W   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int RANK_W    = FRAME_W;
  localparam int CNT_W     = $clog2(FRAMES + 1);
  localparam int CFG_W     = 5;
  localparam int FAULT_W   = 32;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_COMMIT
  } lrupr_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic lookup;
    logic commit;
  } lrupr_cmd_t;

  // Index of the lowest set bit; zero when no bit is set.
  function automatic logic [FRAME_W-1:0] first_one(input logic [FRAMES-1:0] v);
    logic [FRAME_W-1:0] idx;
    idx = '0;
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = FRAME_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

// ===== design/lrupr_ctrl.sv =====
// Controller state machine that sequences the lookup and commit of a reference.
`include "lru_page_replacement_top_macros.svh"

module lrupr_ctrl
  import lrupr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  output lrupr_cmd_t cmd_o
);

  lrupr_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    busy_o       = 1'b1;
    cmd_o.load   = 1'b0;
    cmd_o.lookup = 1'b0;
    cmd_o.commit = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd_o.lookup = 1'b1;
        state_d      = ST_COMMIT;
      end
      ST_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  `LRUPR_ASSERT_NEXT(a_accept_goes_lookup, start_i && !busy_o, state_q == ST_LOOKUP,
                     "accepted word did not enter lookup")

endmodule

// ===== design/lrupr_dp.sv =====
// Datapath: frame store, tag compare, recency ranks, fault counter and result registers.
`include "lru_page_replacement_top_macros.svh"

module lrupr_dp
  import lrupr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lrupr_cmd_t           cmd_i,
  input  logic [PAGE_BITS-1:0] page_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  output logic                 done_o,
  output logic                 fault_o,
  output logic [FRAME_W-1:0]   frame_index_o,
  output logic                 evicted_valid_o,
  output logic [PAGE_BITS-1:0] evicted_page_o,
  output logic [FAULT_W-1:0]   fault_total_o
);

  // Frame store: pages have no reset, valid bits and ranks do.
  logic [PAGE_BITS-1:0] page_q [FRAMES];
  logic [FRAMES-1:0]    valid_q, valid_d;
  logic [RANK_W-1:0]    rank_q [FRAMES];
  logic [RANK_W-1:0]    rank_d [FRAMES];
  logic [CFG_W-1:0]     num_frames_q;
  logic [FAULT_W-1:0]   fault_cnt_q, fault_cnt_d;

  logic [PAGE_BITS-1:0] req_page_q;

  // Lookup results held for the commit cycle.
  logic                 hit_q;
  logic                 evict_q;
  logic [FRAME_W-1:0]   tgt_q;
  logic [RANK_W-1:0]    old_rank_q;
  logic [RANK_W-1:0]    new_rank_q;

  // Result registers.
  logic                 done_q;
  logic                 fault_q;
  logic [FRAME_W-1:0]   frame_idx_q;
  logic                 evict_vld_q;
  logic [PAGE_BITS-1:0] evict_page_q;

  logic [CFG_W-1:0]     n_eff;
  logic [FRAMES-1:0]    active;
  logic [FRAMES-1:0]    vld;
  logic [FRAMES-1:0]    match;
  logic [FRAMES-1:0]    empty;
  logic [FRAMES-1:0]    lru;
  logic [CNT_W-1:0]     used;
  logic                 hit;
  logic                 have_empty;
  logic [FRAME_W-1:0]   tgt;

  always_comb begin
    if (num_frames_q == '0) begin
      n_eff = CFG_W'(1);
    end else if (num_frames_q > CFG_W'(FRAMES)) begin
      n_eff = CFG_W'(FRAMES);
    end else begin
      n_eff = num_frames_q;
    end
  end

  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      active[i] = CFG_W'(i) < n_eff;
      vld[i]    = active[i] && valid_q[i];
      match[i]  = vld[i] && (page_q[i] == req_page_q);
      empty[i]  = active[i] && !valid_q[i];
      // Ranks of valid frames form a permutation, so rank zero is the LRU frame.
      lru[i]    = vld[i] && (rank_q[i] == '0);
    end
    used       = CNT_W'($countones(vld));
    hit        = |match;
    have_empty = |empty;
    if (hit) begin
      tgt = first_one(match);
    end else if (have_empty) begin
      tgt = first_one(empty);
    end else begin
      tgt = first_one(lru);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_page_q <= page_i;
    end
    if (cmd_i.lookup) begin
      hit_q      <= hit;
      evict_q    <= !hit && !have_empty;
      tgt_q      <= tgt;
      old_rank_q <= rank_q[tgt];
      new_rank_q <= (hit || !have_empty) ? RANK_W'(used - 1'b1) : RANK_W'(used);
    end
    if (cmd_i.commit) begin
      if (!hit_q) begin
        page_q[tgt_q] <= req_page_q;
      end
      fault_q      <= !hit_q;
      frame_idx_q  <= tgt_q;
      evict_vld_q  <= evict_q;
      evict_page_q <= evict_q ? page_q[tgt_q] : '0;
    end
  end

  always_comb begin
    valid_d     = valid_q;
    rank_d      = rank_q;
    fault_cnt_d = fault_cnt_q;
    if (cfg_we_i) begin
      valid_d = '0;
      for (int i = 0; i < FRAMES; i++) begin
        rank_d[i] = '0;
      end
    end else if (cmd_i.commit) begin
      if (hit_q || evict_q) begin
        for (int i = 0; i < FRAMES; i++) begin
          if (vld[i] && (rank_q[i] > old_rank_q)) begin
            rank_d[i] = rank_q[i] - 1'b1;
          end
        end
      end
      rank_d[tgt_q] = new_rank_q;
      if (!hit_q) begin
        valid_d[tgt_q] = 1'b1;
        if (fault_cnt_q != '1) begin
          fault_cnt_d = fault_cnt_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= '0;
      for (int i = 0; i < FRAMES; i++) begin
        rank_q[i] <= '0;
      end
      num_frames_q <= CFG_W'(FRAMES);
      fault_cnt_q  <= '0;
      done_q       <= 1'b0;
    end else begin
      valid_q     <= valid_d;
      rank_q      <= rank_d;
      fault_cnt_q <= fault_cnt_d;
      done_q      <= cmd_i.commit;
      if (cfg_we_i) begin
        num_frames_q <= cfg_wdata_i;
      end
    end
  end

  assign done_o          = done_q;
  assign fault_o         = fault_q;
  assign frame_index_o   = frame_idx_q;
  assign evicted_valid_o = evict_vld_q;
  assign evicted_page_o  = evict_page_q;
  assign fault_total_o   = fault_cnt_q;

  `LRUPR_ASSERT(a_single_match, $onehot0(match), "page resident in more than one frame")
  `LRUPR_ASSERT_NEXT(a_done_one_cycle, done_q, !done_q, "result strobe held two cycles")
  `LRUPR_ASSERT(a_hit_no_evict, !(done_q && !fault_q && evict_vld_q),
                "eviction reported on a hit")
  `LRUPR_ASSERT_NEXT(a_cnt_monotonic, 1'b1, fault_cnt_q >= $past(fault_cnt_q),
                     "fault counter decreased")

endmodule

// ===== design/lru_page_replacement_top.sv =====
// Top level of the fully associative LRU page replacement block.
//
// Usage: each input word is one page reference on page_i. A word is accepted
// at a rising clock edge where start is high and busy is low. The block then
// compares the page against all active frames in the lookup step and commits
// the frame, rank and counter updates in the commit step after it. Busy stays
// high through both steps; only when the controller is back in idle can it
// take the next word, so a new word is not taken while the last one is in
// lookup or commit. The result word is registered at the end of commit,
// driven in the cycle after commit, and taken at the edge that ends that
// cycle. done_o marks it for exactly one cycle. The receiver cannot stall:
// done_o is not held, and the result registers keep a result only until the
// next commit. The result holds the fault flag, the frame now holding the
// page, the evicted page if any, and the saturating running fault count.
// The user must write the frame count register with cfg_we_i and cfg_wdata_i
// only while the block is idle; the block does not enforce it. Every write
// empties all frames but keeps the fault count. Reset empties all frames,
// clears the fault count and selects 16 frames.
module lru_page_replacement_top
  import lrupr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [PAGE_BITS-1:0] page_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  output logic                 done_o,
  output logic                 fault_o,
  output logic [FRAME_W-1:0]   frame_index_o,
  output logic                 evicted_valid_o,
  output logic [PAGE_BITS-1:0] evicted_page_o,
  output logic [FAULT_W-1:0]   fault_total_o
);

  // Commands from the sequencer into the datapath.
  lrupr_cmd_t cmd;

  // The controller only sequences; apart from its state register, all state lives in the datapath.
  lrupr_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .cmd_o   (cmd)
  );

  // The datapath holds the frames, ranks, fault counter and result registers.
  lrupr_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .page_i          (page_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .done_o          (done_o),
    .fault_o         (fault_o),
    .frame_index_o   (frame_index_o),
    .evicted_valid_o (evicted_valid_o),
    .evicted_page_o  (evicted_page_o),
    .fault_total_o   (fault_total_o)
  );

endmodule
